>>> src/bbg_pkg.sv
package bbg_pkg;

  localparam int QW  = 16;
  localparam int VW  = 49;
  localparam int SMW = 30;
  localparam int SQW = 63;
  localparam int LNW = 31;
  localparam int RMW = 45;
  localparam int QTW = 15;
  localparam int SQ_STAGES = 31;
  localparam int DV_STAGES = 15;

  typedef logic signed [QW-1:0] q_t;
  typedef q_t [2:0] qvec_t;
  typedef logic signed [VW-1:0] wide_t;
  typedef wide_t [2:0] wvec_t;

  typedef struct packed {
    logic  mode;
    logic  ok;
    qvec_t up;
    qvec_t nrm;
    qvec_t rgt;
    qvec_t upw;
  } side_t;

  function automatic logic [5:0] top_bit(input logic [VW-1:0] x);
    logic [5:0] t;
    t = '0;
    for (int i = 0; i < VW; i++) begin
      if (x[i]) begin
        t = 6'(i);
      end
    end
    return t;
  endfunction

  function automatic q_t round_q28(input wide_t c);
    logic [VW-1:0] m;
    logic [VW-1:0] q;
    q_t r;
    m = c[VW-1] ? VW'(-c) : VW'(c);
    q = (m + VW'(8192)) >> 14;
    if (c[VW-1]) begin
      r = q_t'(-$signed(q[QW:0]));
    end else if (q > VW'(32767)) begin
      r = 16'sd32767;
    end else begin
      r = q_t'(q[QW-1:0]);
    end
    return r;
  endfunction

endpackage

>>> src/billboard_basis_generator_unit.sv
// Channel | Direction | Ports            | Contents
// in      | slave     | in_tvalid/tready | view, up (16b each), camera, object (48b each)
// out     | master    | out_tvalid/tready| right, up, normal axes; tuser = degenerate
// cfg     | write     | cfg_wr_en        | orientation_mode (bit 0)
//
// One transaction is accepted every cycle while the output is not stalled.
// The pipeline is made of three normalize units, each with a 31-stage square root
// and a 15-stage divider, plus two 3-stage cross-product units and three single registers.
// The whole pipeline advances together and holds while the output is stalled.
// Reset is synchronous and clears only valid bits and the mode register.
module billboard_basis_generator_unit import bbg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // view_dir_x/y/z, up_dir_x/y/z, camera_pos_x/y/z, object_pos_x/y/z
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // right_x/y/z, upward_x/y/z, normal_x/y/z
  output logic [143:0] out_tdata,
  // degenerate
  output logic         out_tuser,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);

  logic  en, mode_r;
  logic  t0_v_r;
  wvec_t t0_d_r;
  side_t t0_side_r;
  qvec_t vin, uin;

  logic  n1_v, n2_v, n3_v, c1_v, c2_v, r_v_r;
  qvec_t n1_q, n2_q, n3_q;
  logic  n1_zero, n2_zero, n3_zero;
  side_t n1_side, n2_side, n3_side, c1_side, c2_side, side1, side2, side3, r_side_r;
  wvec_t c1_c, c2_c, r_c_r;

  logic out_v_r, out_deg_r;
  logic [143:0] out_data_r;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  for (genvar i = 0; i < 3; i++) begin : g_in
    assign vin[i] = in_tdata[16*i +: 16];
    assign uin[i] = in_tdata[48 + 16*i +: 16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r  <= 1'b0;
      r_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      t0_v_r  <= in_tvalid;
      r_v_r   <= c2_v;
      out_v_r <= n3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t0_d_r[i] <= $signed({in_tdata[96 + 48*i + 47], in_tdata[96 + 48*i +: 48]})
                   - $signed({in_tdata[240 + 48*i + 47], in_tdata[240 + 48*i +: 48]});
        t0_side_r.nrm[i] <= (vin[i] == -16'sd32768) ? 16'sd32767 : -vin[i];
      end
      t0_side_r.mode <= mode_r;
      t0_side_r.ok   <= 1'b1;
      t0_side_r.up   <= uin;
      t0_side_r.rgt  <= '0;
      t0_side_r.upw  <= '0;
    end
  end

  bbg_norm u_norm_pos (
    .clk, .rst_n, .en,
    .in_valid(t0_v_r), .in_vec(t0_d_r), .in_side(t0_side_r),
    .out_valid(n1_v), .out_q(n1_q), .out_zero(n1_zero), .out_side(n1_side)
  );

  always_comb begin
    side1 = n1_side;
    if (n1_side.mode) begin
      side1.nrm = n1_q;
      side1.ok  = !n1_zero;
    end
  end

  bbg_cross u_cross_right (
    .clk, .rst_n, .en,
    .in_valid(n1_v), .a(side1.up), .b(side1.nrm), .alt_en(!side1.mode),
    .in_side(side1), .out_valid(c1_v), .out_c(c1_c), .out_side(c1_side)
  );

  bbg_norm u_norm_right (
    .clk, .rst_n, .en,
    .in_valid(c1_v), .in_vec(c1_c), .in_side(c1_side),
    .out_valid(n2_v), .out_q(n2_q), .out_zero(n2_zero), .out_side(n2_side)
  );

  always_comb begin
    side2     = n2_side;
    side2.rgt = n2_q;
    side2.ok  = n2_side.ok && !n2_zero;
  end

  bbg_cross u_cross_up (
    .clk, .rst_n, .en,
    .in_valid(n2_v), .a(side2.nrm), .b(side2.rgt), .alt_en(1'b0),
    .in_side(side2), .out_valid(c2_v), .out_c(c2_c), .out_side(c2_side)
  );

  always_comb begin
    side3 = c2_side;
    for (int i = 0; i < 3; i++) begin
      side3.upw[i] = round_q28(c2_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_c_r    <= c2_c;
      r_side_r <= side3;
    end
  end

  bbg_norm u_norm_up (
    .clk, .rst_n, .en,
    .in_valid(r_v_r), .in_vec(r_c_r), .in_side(r_side_r),
    .out_valid(n3_v), .out_q(n3_q), .out_zero(n3_zero), .out_side(n3_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      if (n3_side.ok && (n3_side.mode || !n3_zero)) begin
        out_data_r <= {n3_side.nrm, (n3_side.mode ? n3_side.upw : n3_q), n3_side.rgt};
        out_deg_r  <= 1'b0;
      end else begin
        out_data_r <= '0;
        out_deg_r  <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_deg_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero axes");

  a_right_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      $signed(out_tdata[15:0]) <= 16'sd16384 && $signed(out_tdata[15:0]) >= -16'sd16384)
    else $error("right axis component out of range");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

endmodule

>>> src/bbg_cross.sv
module bbg_cross import bbg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  qvec_t a,
  input  qvec_t b,
  input  logic  alt_en,
  input  side_t in_side,
  output logic  out_valid,
  output wvec_t out_c,
  output side_t out_side
);

  qvec_t a_alt;
  logic signed [31:0] pp_r [3];
  logic signed [31:0] pm_r [3];
  logic signed [31:0] ap_r [3];
  logic signed [31:0] am_r [3];
  logic signed [32:0] c_r  [3];
  logic signed [32:0] ca_r [3];
  logic  v1_r, v2_r, v3_r;
  logic  alt1_r, alt2_r;
  side_t side1_r, side2_r, side3_r;
  wvec_t c3_r;

  assign a_alt = {a[2], a[0], a[1]};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        pp_r[i] <= a[J] * b[K];
        pm_r[i] <= a[K] * b[J];
        ap_r[i] <= a_alt[J] * b[K];
        am_r[i] <= a_alt[K] * b[J];
        c_r[i]  <= 33'(pp_r[i]) - 33'(pm_r[i]);
        ca_r[i] <= 33'(ap_r[i]) - 33'(am_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= in_side;
      alt1_r  <= alt_en;
      side2_r <= side1_r;
      alt2_r  <= alt1_r;
      side3_r <= side2_r;
      for (int i = 0; i < 3; i++) begin
        if (alt2_r && c_r[0] == '0 && c_r[1] == '0 && c_r[2] == '0) begin
          c3_r[i] <= VW'(ca_r[i]);
        end else begin
          c3_r[i] <= VW'(c_r[i]);
        end
      end
    end
  end

  assign out_valid = v3_r;
  assign out_c     = c3_r;
  assign out_side  = side3_r;

endmodule

>>> src/bbg_norm.sv
module bbg_norm import bbg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  wvec_t in_vec,
  input  side_t in_side,
  output logic  out_valid,
  output qvec_t out_q,
  output logic  out_zero,
  output side_t out_side
);

  logic [2:0][VW-1:0] s1_mag_r, s2_mag_r, s3_mag_r;
  logic [2:0] s1_neg_r, s2_neg_r, s3_neg_r, s4_neg_r, s5_neg_r;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  side_t s1_side_r, s2_side_r, s3_side_r, s4_side_r, s5_side_r;
  logic [VW-1:0] s2_or_r;
  logic [5:0] s3_top_r;
  logic s3_zero_r, s4_zero_r, s5_zero_r;
  logic [2:0][SMW-1:0] s4_sm_r, s5_sm_r;
  logic [2:0][2*SMW-1:0] s5_sq_r;

  logic [SQW-1:0] q_x_r [SQ_STAGES+1];
  logic [SQW-1:0] q_r_r [SQ_STAGES+1];
  logic [2:0][SMW-1:0] q_sm_r [SQ_STAGES+1];
  logic [2:0] q_neg_r [SQ_STAGES+1];
  logic q_zero_r [SQ_STAGES+1];
  logic q_v_r [SQ_STAGES+1];
  side_t q_side_r [SQ_STAGES+1];

  logic [2:0][RMW-1:0] d_rem_r [DV_STAGES+1];
  logic [2:0][QTW-1:0] d_q_r [DV_STAGES+1];
  logic [LNW-1:0] d_len_r [DV_STAGES+1];
  logic [2:0] d_neg_r [DV_STAGES+1];
  logic d_zero_r [DV_STAGES+1];
  logic d_v_r [DV_STAGES+1];
  side_t d_side_r [DV_STAGES+1];

  logic o_v_r, o_zero_r;
  qvec_t o_q_r;
  side_t o_side_r;
  logic [LNW-1:0] len;

  assign len = q_r_r[SQ_STAGES][LNW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      q_v_r[0] <= 1'b0;
      d_v_r[0] <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      q_v_r[0] <= s5_v_r;
      d_v_r[0] <= q_v_r[SQ_STAGES];
      o_v_r <= d_v_r[DV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg_r[i] <= in_vec[i][VW-1];
        s1_mag_r[i] <= in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
      end
      s1_side_r <= in_side;

      s2_or_r   <= s1_mag_r[0] | s1_mag_r[1] | s1_mag_r[2];
      s2_mag_r  <= s1_mag_r;
      s2_neg_r  <= s1_neg_r;
      s2_side_r <= s1_side_r;

      s3_top_r  <= top_bit(s2_or_r);
      s3_zero_r <= (s2_or_r == '0);
      s3_mag_r  <= s2_mag_r;
      s3_neg_r  <= s2_neg_r;
      s3_side_r <= s2_side_r;

      for (int i = 0; i < 3; i++) begin
        s4_sm_r[i] <= SMW'(({s3_mag_r[i], 29'b0}) >> s3_top_r);
      end
      s4_zero_r <= s3_zero_r;
      s4_neg_r  <= s3_neg_r;
      s4_side_r <= s3_side_r;

      for (int i = 0; i < 3; i++) begin
        s5_sq_r[i] <= s4_sm_r[i] * s4_sm_r[i];
      end
      s5_sm_r   <= s4_sm_r;
      s5_zero_r <= s4_zero_r;
      s5_neg_r  <= s4_neg_r;
      s5_side_r <= s4_side_r;

      q_x_r[0]    <= SQW'(s5_sq_r[0]) + SQW'(s5_sq_r[1]) + SQW'(s5_sq_r[2]);
      q_r_r[0]    <= '0;
      q_sm_r[0]   <= s5_sm_r;
      q_neg_r[0]  <= s5_neg_r;
      q_zero_r[0] <= s5_zero_r;
      q_side_r[0] <= s5_side_r;

      for (int i = 0; i < 3; i++) begin
        d_rem_r[0][i] <= {1'b0, q_sm_r[SQ_STAGES][i], 14'b0} + RMW'(len >> 1);
      end
      d_q_r[0]    <= '0;
      d_len_r[0]  <= len;
      d_neg_r[0]  <= q_neg_r[SQ_STAGES];
      d_zero_r[0] <= q_zero_r[SQ_STAGES];
      d_side_r[0] <= q_side_r[SQ_STAGES];

      for (int i = 0; i < 3; i++) begin
        o_q_r[i] <= d_neg_r[DV_STAGES][i] ? -$signed({1'b0, d_q_r[DV_STAGES][i]})
                                          : $signed({1'b0, d_q_r[DV_STAGES][i]});
      end
      o_zero_r <= d_zero_r[DV_STAGES];
      o_side_r <= d_side_r[DV_STAGES];
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam int SH = 2 * (SQ_STAGES - 1 - k);
    logic [SQW-1:0] bit_val, trial;
    assign bit_val = SQW'(1) << SH;
    assign trial   = q_r_r[k] + bit_val;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_v_r[k+1] <= 1'b0;
      end else if (en) begin
        q_v_r[k+1] <= q_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (q_x_r[k] >= trial) begin
          q_x_r[k+1] <= q_x_r[k] - trial;
          q_r_r[k+1] <= (q_r_r[k] >> 1) + bit_val;
        end else begin
          q_x_r[k+1] <= q_x_r[k];
          q_r_r[k+1] <= q_r_r[k] >> 1;
        end
        q_sm_r[k+1]   <= q_sm_r[k];
        q_neg_r[k+1]  <= q_neg_r[k];
        q_zero_r[k+1] <= q_zero_r[k];
        q_side_r[k+1] <= q_side_r[k];
      end
    end
  end

  for (genvar j = 0; j < DV_STAGES; j++) begin : g_div
    localparam int B = DV_STAGES - 1 - j;
    logic [RMW-1:0] dsor;
    assign dsor = RMW'(d_len_r[j]) << B;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[j+1] <= 1'b0;
      end else if (en) begin
        d_v_r[j+1] <= d_v_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (d_rem_r[j][i] >= dsor) begin
            d_rem_r[j+1][i] <= d_rem_r[j][i] - dsor;
            d_q_r[j+1][i]   <= d_q_r[j][i] | (QTW'(1) << B);
          end else begin
            d_rem_r[j+1][i] <= d_rem_r[j][i];
            d_q_r[j+1][i]   <= d_q_r[j][i];
          end
        end
        d_len_r[j+1]  <= d_len_r[j];
        d_neg_r[j+1]  <= d_neg_r[j];
        d_zero_r[j+1] <= d_zero_r[j];
        d_side_r[j+1] <= d_side_r[j];
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_q     = o_q_r;
  assign out_zero  = o_zero_r;
  assign out_side  = o_side_r;

endmodule

>>> dv/bbg_checker.sv
module bbg_checker import bbg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [383:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [143:0] out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [143:0] axes;
    logic         degenerate;
  } basis_t;

  basis_t basis_q[$];
  logic   face_camera;
  int     mismatches;

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void cross_vec(input longint a[3], input longint b[3],
                                    output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic bit to_unit(input longint v[3], output longint o[3]);
    longint unsigned m[3];
    longint unsigned mx, sum, len, q;
    int top;
    mx  = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    top = -1;
    while (top < 63 && (mx >> (top + 1)) != 0) top++;
    for (int i = 0; i < 3; i++) begin
      if (top > 29) m[i] = m[i] >> (top - 29);
      else m[i] = m[i] << (29 - top);
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + len / 2) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint round_to_q14(input longint x);
    longint unsigned m;
    longint q;
    m = x < 0 ? -x : x;
    q = longint'((m + 8192) >> 14);
    if (x < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic basis_t compute_basis(input logic [383:0] d, input logic mode);
    longint up[3], nrm[3], rgt[3], upw[3], c[3], sw[3], dv[3];
    logic signed [15:0] v16;
    bit ok;
    basis_t b;
    for (int i = 0; i < 3; i++) begin
      up[i] = $signed(d[16*(3+i) +: 16]);
    end
    if (!mode) begin
      for (int i = 0; i < 3; i++) begin
        v16 = d[16*i +: 16];
        nrm[i] = (v16 == -16'sd32768) ? 32767 : -longint'(v16);
      end
      cross_vec(up, nrm, c);
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
        sw[0] = up[1];
        sw[1] = up[0];
        sw[2] = up[2];
        cross_vec(sw, nrm, c);
      end
      ok = to_unit(c, rgt);
      if (ok) begin
        cross_vec(nrm, rgt, c);
        ok = to_unit(c, upw);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        dv[i] = longint'($signed(d[96+48*i +: 48])) - longint'($signed(d[240+48*i +: 48]));
      end
      ok = to_unit(dv, nrm);
      if (ok) begin
        cross_vec(up, nrm, c);
        ok = to_unit(c, rgt);
      end
      if (ok) begin
        cross_vec(nrm, rgt, c);
        for (int i = 0; i < 3; i++) upw[i] = round_to_q14(c[i]);
      end
    end
    b.axes = '0;
    b.degenerate = !ok;
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        b.axes[16*i +: 16]     = rgt[i][15:0];
        b.axes[16*(3+i) +: 16] = upw[i][15:0];
        b.axes[16*(6+i) +: 16] = nrm[i][15:0];
      end
    end
    return b;
  endfunction

  always @(posedge clk) begin
    basis_t want;
    if (!rst_n) begin
      face_camera <= 1'b0;
      fail_count  <= 0;
      pending     <= 0;
      mismatches  = 0;
    end else begin
      if (cfg_wr_en) face_camera <= cfg_wr_data;
      if (in_tvalid && in_tready) basis_q.push_back(compute_basis(in_tdata, face_camera));
      if (out_tvalid && out_tready) begin
        if (basis_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatches < 10) $display("ERROR: unexpected output transaction %h", out_tdata);
          mismatches++;
        end else begin
          want = basis_q.pop_front();
          if (want.axes !== out_tdata || want.degenerate !== out_tuser) begin
            fail_count <= fail_count + 1;
            if (mismatches < 10) begin
              for (int i = 0; i < 9; i++) begin
                if (want.axes[16*i +: 16] !== out_tdata[16*i +: 16]) begin
                  $display("ERROR: axis field %0d expected %0d got %0d", i,
                           $signed(want.axes[16*i +: 16]), $signed(out_tdata[16*i +: 16]));
                end
              end
              if (want.degenerate !== out_tuser) begin
                $display("ERROR: degenerate expected %0b got %0b", want.degenerate, out_tuser);
              end
            end
            mismatches++;
          end
        end
      end
      pending <= basis_q.size();
    end
  end
endmodule

>>> dv/tb_billboard_basis_generator_unit.sv
module tb_billboard_basis_generator_unit import bbg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN = 400;

  typedef struct packed {
    logic signed [47:0] oz, oy, ox, cz, cy, cx;
    logic signed [15:0] uz, uy, ux, vz, vy, vx;
  } record_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [383:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_wr_data = 1'b0;
  logic         in_acc = 1'b0;
  logic         hold_output = 1'b0;
  bit           steady = 1'b0;
  int           fail_count, pending, idle_cycles, rx_wait;

  always #4 clk = ~clk;

  billboard_basis_generator_unit u_top (.*);

  bbg_checker u_checker (.*);

  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  always @(negedge clk) begin
    if (hold_output || rx_wait > 0) begin
      out_tready <= 1'b0;
      if (rx_wait > 0) rx_wait--;
    end else begin
      out_tready <= 1'b1;
      rx_wait = gap_len();
    end
  end

  task automatic send(input record_t r);
    int g;
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(negedge clk); while (!in_acc);
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain_and_set(input logic mode);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic signed [47:0] rand48(input bit narrow);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (narrow) return $signed(48'($signed(w[11:0])));
    return w[47:0];
  endfunction

  function automatic record_t rand_record(input logic mode);
    record_t r;
    int kind;
    bit narrow;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    kind   = $urandom_range(0, 19);
    narrow = $urandom_range(0, 1);
    r.cx = rand48(narrow); r.cy = rand48(narrow); r.cz = rand48(narrow);
    r.ox = rand48(narrow); r.oy = rand48(narrow); r.oz = rand48(narrow);
    if (kind == 0) begin
      r.ux = r.vx; r.uy = r.vy; r.uz = r.vz;
    end else if (kind == 1) begin
      r.ux = r.vy; r.uy = r.vy; r.uz = r.vz; r.vx = r.vy;
    end else if (kind == 2) begin
      r.ox = r.cx; r.oy = r.cy; r.oz = r.cz;
    end else if (kind == 3) begin
      r.cx = r.ox + r.ux; r.cy = r.oy + r.uy; r.cz = r.oz + r.uz;
    end else if (kind == 4) begin
      r.ux = 16'($signed($urandom_range(0, 6)) - 3);
      r.vz = 16'($signed($urandom_range(0, 6)) - 3);
    end
    return r;
  endfunction

  function automatic record_t mk(input int vx, vy, vz, ux, uy, uz,
                                 input longint cx, cy, cz, ox, oy, oz);
    record_t r;
    r.vx = 16'(vx); r.vy = 16'(vy); r.vz = 16'(vz);
    r.ux = 16'(ux); r.uy = 16'(uy); r.uz = 16'(uz);
    r.cx = 48'(cx); r.cy = 48'(cy); r.cz = 48'(cz);
    r.ox = 48'(ox); r.oy = 48'(oy); r.oz = 48'(oz);
    return r;
  endfunction

  initial begin
    longint pmax, pmin;
    pmax = 64'sh0000_7FFF_FFFF_FFFF;
    pmin = -64'sh0000_8000_0000_0000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(0, 0, -16384, 0, 16384, 0, 0, 0, 0, 0, 0, 0));
    send(mk(-32768, -32768, -32768, 32767, -32768, 0, pmax, pmax, pmax, pmin, pmin, pmin));
    send(mk(0, 0, -16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
    send(mk(0, -16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0));
    send(mk(-1, -1, -1, 5, 5, 5, 0, 0, 0, 0, 0, 0));
    send(mk(32767, 32767, 32767, -32768, 32767, -1, pmin, pmin, pmin, pmax, pmax, pmax));
    send(mk(100, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    send(mk(0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0));
    drain_and_set(1'b1);
    send(mk(0, 0, 0, 0, 16384, 0, 7, -3, 9, 7, -3, 9));
    send(mk(0, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0));
    send(mk(-1, -1, -1, 0, 16384, 0, pmax, pmax, pmax, pmin, pmin, pmin));
    send(mk(-1, -1, -1, 0, 16384, 0, pmin, 0, pmin, pmax, 0, pmax));
    send(mk(0, 0, 0, 0, 16384, 0, 0, 5, 0, 0, 0, 0));
    send(mk(0, 0, 0, 0, 0, 0, 1, 2, 3, 0, 0, 0));
    send(mk(32767, 0, 0, -32768, -32768, -32768, 1, 0, 0, 0, 0, 0));
    send(mk(0, 0, 0, 32767, 32767, 32767, 0, 0, pmax, 0, 0, pmin));
    send(mk(0, 0, 0, 16384, 0, 0, 1000, 20, -300, -1, 2, 3));
    send(mk(0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0));

    for (int phase = 0; phase < 4; phase++) begin
      drain_and_set(phase[0]);
      steady = (phase == 2);
      if (phase == 1) begin
        fork
          begin
            hold_output = 1'b1;
            repeat (600) @(negedge clk);
            hold_output = 1'b0;
          end
        join_none
      end
      repeat (310) send(rand_record(phase[0]));
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
src/bbg_pkg.sv
src/bbg_cross.sv
src/bbg_norm.sv
src/billboard_basis_generator_unit.sv
dv/bbg_checker.sv
dv/tb_billboard_basis_generator_unit.sv
